@@ sv/bbc_pkg.sv @@
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants of the block buffer cache
// Entry layout, command and status codes, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

  // Table size and the index width that follows from it.
  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // Field widths of one word on each side.
  localparam int DEV_W    = 8;
  localparam int BLK_W    = 32;
  localparam int SEL_W    = 5;
  localparam int TIME_W   = 31;
  localparam int COUNT_W  = 6;
  localparam int IN_W     = 80;
  localparam int OUT_W    = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;
  localparam logic [TIME_W-1:0]  TIME_MAX  = 31'h7fffffff;

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PIN     = 2'd2,
    CMD_UNPIN   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  // One stored entry of the tag table (the valid bit lives in flip-flops).
  typedef struct packed {
    logic [DEV_W-1:0]   device;
    logic [BLK_W-1:0]   block_number;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  last_use;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;    // capture the input word
    logic             rd;      // read one table entry
    logic             commit;  // apply the update and load the result
    logic [IDX_W-1:0] addr;    // scan position during a get
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_get;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ sv/bbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// bbc_ctrl: sequencing controller of the block buffer cache
// Accepts one input word, walks the tag table one entry a cycle for a get
// or reads the addressed entry once for the other commands, then commits.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire bbc_pkg::stat_t stat,
  output bbc_pkg::ctrl_t      ctrl
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_WAIT   = 4'b0100,
    S_UPDATE = 4'b1000
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [bbc_pkg::IDX_W-1:0] cnt;
  logic [bbc_pkg::IDX_W-1:0] cnt_next;

  // Next state and command decode.
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    in_ready    = 1'b0;
    ctrl.load   = 1'b0;
    ctrl.rd     = 1'b0;
    ctrl.commit = 1'b0;
    ctrl.addr   = cnt;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load  = 1'b1;
          cnt_next   = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ctrl.rd = 1'b1;
        if (!stat.is_get || cnt == bbc_pkg::LAST_IDX) begin
          state_next = S_WAIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_WAIT: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (stat.out_free) begin
          ctrl.commit = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and scan counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

`ifndef SYNTHESIS
  // A read is only issued while scanning.
  assert property (@(posedge clk) disable iff (rst)
    ctrl.rd |-> state == S_SCAN)
    else $error("bbc_ctrl: read outside the scan state");

  // A commit always follows the drain cycle of the last read.
  assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_UPDATE) |-> $past(state == S_WAIT))
    else $error("bbc_ctrl: update entered without drain cycle");

  // Loading a new word never overlaps a commit or a read.
  assert property (@(posedge clk) disable iff (rst)
    !(ctrl.load && (ctrl.commit || ctrl.rd)))
    else $error("bbc_ctrl: load overlaps work on the previous word");
`endif

endmodule

`default_nettype wire

@@ sv/bbc_dp.sv @@
// ----------------------------------------------------------------------------
// bbc_dp: datapath of the block buffer cache
// Holds the tag memory, valid bits, scan accumulators for the lookup and
// the victim search, the update logic and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_dp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [bbc_pkg::IN_W-1:0] in_data,
  input  wire bbc_pkg::ctrl_t        ctrl,
  output bbc_pkg::stat_t             stat,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [bbc_pkg::OUT_W-1:0]  out_data
);

  // Captured input word.
  bbc_pkg::cmd_t                    cmd_q;
  logic [bbc_pkg::DEV_W-1:0]        dev_q;
  logic [bbc_pkg::BLK_W-1:0]        blk_q;
  logic [bbc_pkg::SEL_W-1:0]        idx_q;
  logic [bbc_pkg::TIME_W-1:0]       now_q;

  // Tag memory and per-entry flags.
  bbc_pkg::entry_t                  mem [bbc_pkg::ENTRIES];
  logic [bbc_pkg::ENTRIES-1:0]      written;
  logic [bbc_pkg::ENTRIES-1:0]      valid_bits;

  // Read side.
  logic [bbc_pkg::IDX_W-1:0]        rd_addr;
  bbc_pkg::entry_t                  rd_word;
  logic                             rd_written;
  logic [bbc_pkg::IDX_W-1:0]        rd_idx;
  logic                             eval;
  bbc_pkg::entry_t                  eff;

  // Scan accumulators.
  logic                             found;
  logic [bbc_pkg::IDX_W-1:0]        match_idx;
  bbc_pkg::entry_t                  match_word;
  logic                             any;
  logic [bbc_pkg::IDX_W-1:0]        victim;
  logic [bbc_pkg::TIME_W-1:0]       oldest;

  // Update decode.
  logic                             wr_want;
  logic                             wr_en;
  logic                             set_valid;
  logic [bbc_pkg::IDX_W-1:0]        wr_addr;
  bbc_pkg::entry_t                  wr_word;
  logic [bbc_pkg::SEL_W-1:0]        res_slot;
  logic                             res_hit;
  logic                             res_fill;
  bbc_pkg::status_t                 res_status;
  logic                             oob;
  logic                             is_match;

  assign stat.is_get   = (cmd_q == bbc_pkg::CMD_GET);
  assign stat.out_free = !out_valid || out_ready;

  // Input word capture.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q <= bbc_pkg::cmd_t'(in_data[1:0]);
      dev_q <= in_data[9:2];
      blk_q <= in_data[41:10];
      idx_q <= in_data[46:42];
      now_q <= in_data[77:47];
    end
  end

  // A get walks the table; the other commands read the addressed entry.
  assign rd_addr = stat.is_get ? ctrl.addr : bbc_pkg::IDX_W'(idx_q);
  assign oob     = int'(idx_q) >= bbc_pkg::ENTRIES;

  // Memory read and write ports.
  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      rd_word <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
  end

  // Read bookkeeping; an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      eval       <= 1'b0;
      rd_written <= 1'b0;
      rd_idx     <= '0;
    end else begin
      eval <= ctrl.rd;
      if (ctrl.rd) begin
        rd_written <= written[rd_addr];
        rd_idx     <= rd_addr;
      end
    end
  end

  assign eff      = rd_written ? rd_word : '0;
  assign is_match = (eff.device == dev_q) && (eff.block_number == blk_q);

  // Lookup keeps the first match; victim search keeps the last of the
  // least timestamps among unreferenced entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      found  <= 1'b0;
      any    <= 1'b0;
      oldest <= bbc_pkg::TIME_MAX;
    end else if (ctrl.load) begin
      found  <= 1'b0;
      any    <= 1'b0;
      oldest <= bbc_pkg::TIME_MAX;
    end else if (eval && stat.is_get) begin
      if (!found && is_match) begin
        found <= 1'b1;
      end
      if (eff.count == '0 && eff.last_use <= oldest) begin
        any    <= 1'b1;
        oldest <= eff.last_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eval && stat.is_get) begin
      if (!found && is_match) begin
        match_idx  <= rd_idx;
        match_word <= eff;
      end
      if (eff.count == '0 && eff.last_use <= oldest) begin
        victim <= rd_idx;
      end
    end
  end

  // Result and table update for the captured command.
  always_comb begin
    wr_want    = 1'b0;
    set_valid  = 1'b0;
    wr_addr    = rd_idx;
    wr_word    = eff;
    res_slot   = idx_q;
    res_hit    = 1'b0;
    res_fill   = 1'b0;
    res_status = bbc_pkg::ST_OK;
    case (cmd_q)
      bbc_pkg::CMD_GET: begin
        if (found) begin
          wr_want   = 1'b1;
          set_valid = 1'b1;
          wr_addr   = match_idx;
          wr_word   = match_word;
          res_slot  = bbc_pkg::SEL_W'(match_idx);
          res_hit   = 1'b1;
          res_fill  = !valid_bits[match_idx];
          if (match_word.count >= bbc_pkg::COUNT_MAX) begin
            wr_word.count = bbc_pkg::COUNT_MAX;
            res_status    = bbc_pkg::ST_OVERFLOW;
          end else begin
            wr_word.count = match_word.count + 1'b1;
          end
        end else if (any) begin
          wr_want              = 1'b1;
          set_valid            = 1'b1;
          wr_addr              = victim;
          wr_word.device       = dev_q;
          wr_word.block_number = blk_q;
          wr_word.count        = bbc_pkg::COUNT_W'(1);
          wr_word.last_use     = now_q;
          res_slot             = bbc_pkg::SEL_W'(victim);
          res_fill             = 1'b1;
        end else begin
          res_slot   = '0;
          res_status = bbc_pkg::ST_NO_FREE;
        end
      end
      bbc_pkg::CMD_PIN: begin
        if (!oob) begin
          if (eff.count >= bbc_pkg::COUNT_MAX) begin
            res_status = bbc_pkg::ST_OVERFLOW;
          end else begin
            wr_want       = 1'b1;
            wr_word.count = eff.count + 1'b1;
          end
        end
      end
      bbc_pkg::CMD_RELEASE, bbc_pkg::CMD_UNPIN: begin
        if (!oob) begin
          if (eff.count == '0) begin
            res_status = bbc_pkg::ST_UNDERFLOW;
          end else begin
            wr_want       = 1'b1;
            wr_word.count = eff.count - 1'b1;
            // The last release stamps the time of use.
            if (cmd_q == bbc_pkg::CMD_RELEASE && eff.count == bbc_pkg::COUNT_W'(1)) begin
              wr_word.last_use = now_q;
            end
          end
        end
      end
      default: begin
        wr_want = 1'b0;
      end
    endcase
  end

  assign wr_en = ctrl.commit && wr_want;

  // Per-entry flags, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      valid_bits <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
      if (set_valid) begin
        valid_bits[wr_addr] <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      out_data <= {7'd0, res_status, res_fill, res_hit, res_slot};
    end
  end

`ifndef SYNTHESIS
  // A result is only committed into a free output register.
  assert property (@(posedge clk) disable iff (rst)
    ctrl.commit |-> (!out_valid || out_ready))
    else $error("bbc_dp: commit overwrote a pending result");

  // A new result appears only after a commit.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.commit))
    else $error("bbc_dp: result without commit");

  // The memory is never read and written in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    !(wr_en && ctrl.rd))
    else $error("bbc_dp: read and write collide");

  // A get that wrote an entry leaves it valid.
  assert property (@(posedge clk) disable iff (rst)
    (wr_en && set_valid) |=> valid_bits[$past(wr_addr)])
    else $error("bbc_dp: got entry not marked valid");
`endif

endmodule

`default_nettype wire

@@ sv/block_buffer_cache_lru.sv @@
// ----------------------------------------------------------------------------
// block_buffer_cache_lru: LRU block buffer cache tag table
// Fully associative table of cached disk blocks with reference counts,
// least-recently-used replacement and saturating count updates.
// ----------------------------------------------------------------------------
// Each input word is one command and gives exactly one result word. A get
// walks the whole table before the next word can be accepted, because the
// lookup and the victim search walk the single read port of the tag memory
// one entry a cycle; release, pin and unpin read the addressed entry once.
// A new word is accepted while the previous result still waits in the
// output register. After reset every entry holds device 0, block 0, count
// 0 and time 0, with no reset sweep needed.
`default_nettype none

module block_buffer_cache_lru (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0: cmd[1:0], device[9:2], block_number[41:10],
  // entry_index[46:42], now[77:47], zero fill[79:78].
  input  wire logic [bbc_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // Fields from bit 0: slot[4:0], hit[5], needs_fill[6], status[8:7],
  // zero fill[15:9].
  output logic [bbc_pkg::OUT_W-1:0]         m_axis_tdata
);

  bbc_pkg::ctrl_t ctrl;
  bbc_pkg::stat_t stat;

  // Sequencing controller.
  bbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // Tag memory, search and update datapath.
  bbc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ bench/tb_block_buffer_cache_lru.sv @@
// ----------------------------------------------------------------------------
// tb_block_buffer_cache_lru: self-checking bench for the LRU buffer cache
// Drives a directed table of commands, then several phases of random ones
// under varied flow control, and checks every result word against a
// cycle-free predictor of the tag table.
// ----------------------------------------------------------------------------
module tb_block_buffer_cache_lru;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GET_CYCLES  = bbc_pkg::ENTRIES + 3;
  localparam int LONG_STALL  = 400;
  localparam int STUCK_LIMIT = 4000;
  localparam int PHASE_ITEMS = 50;

  // Idle and stall percentages and the share of gets in each random phase.
  localparam int SEND_PCT[4] = '{0, 61, 0, 14};
  localparam int RECV_PCT[4] = '{0, 0, 61, 14};
  localparam int GET_PCT[4]  = '{40, 40, 40, 60};

  // One command word, packed from bit 0 up: cmd, device, block, index, now.
  typedef struct packed {
    logic [bbc_pkg::TIME_W-1:0] now;
    logic [bbc_pkg::SEL_W-1:0]  idx;
    logic [bbc_pkg::BLK_W-1:0]  blk;
    logic [bbc_pkg::DEV_W-1:0]  dev;
    bbc_pkg::cmd_t              cmd;
  } request_t;

  // One result word, packed from bit 0 up: slot, hit, needs_fill, status.
  typedef struct packed {
    bbc_pkg::status_t          status;
    logic                      fill;
    logic                      hit;
    logic [bbc_pkg::SEL_W-1:0] slot;
  } reply_t;

  // A row of the directed table; stride steps block and index per repeat.
  typedef struct {
    bbc_pkg::cmd_t              cmd;
    logic [bbc_pkg::DEV_W-1:0]  dev;
    logic [bbc_pkg::BLK_W-1:0]  blk;
    logic [bbc_pkg::SEL_W-1:0]  idx;
    logic [bbc_pkg::TIME_W-1:0] now;
    int                         reps;
    bit                         stride;
    bit                         typed;
    reply_t                     want;
  } row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [bbc_pkg::IN_W-1:0]     s_axis_tdata = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [bbc_pkg::OUT_W-1:0]    m_axis_tdata;

  // Mirror of the tag table as the block should hold it.
  logic [bbc_pkg::DEV_W-1:0]    held_dev   [bbc_pkg::ENTRIES];
  logic [bbc_pkg::BLK_W-1:0]    held_blk   [bbc_pkg::ENTRIES];
  logic                         held_valid [bbc_pkg::ENTRIES];
  logic [bbc_pkg::COUNT_W-1:0]  held_refs  [bbc_pkg::ENTRIES];
  logic [bbc_pkg::TIME_W-1:0]   held_stamp [bbc_pkg::ENTRIES];

  reply_t                       pending_replies[$];
  int                           error_count = 0;
  int                           send_idle_pct = 0;
  int                           recv_stall_pct = 0;
  bit                           stall_request = 0;
  int                           stuck_cycles = 0;
  logic [bbc_pkg::TIME_W-1:0]   tick = '0;

  block_buffer_cache_lru DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Applies one command to the mirrored table and returns the result word.
  function automatic reply_t predict_reply(request_t rq);
    reply_t                     rp;
    int                         pick;
    bit                         found;
    bit                         any_free;
    logic [bbc_pkg::TIME_W-1:0] oldest;
    rp = '{status: bbc_pkg::ST_OK, fill: 1'b0, hit: 1'b0, slot: rq.idx};
    if (rq.cmd == bbc_pkg::CMD_GET) begin
      found = 0;
      pick = 0;
      for (int i = bbc_pkg::ENTRIES - 1; i >= 0; i--) begin
        if (held_dev[i] == rq.dev && held_blk[i] == rq.blk) begin
          found = 1;
          pick = i;
        end
      end
      if (found) begin
        if (held_refs[pick] >= bbc_pkg::COUNT_MAX) begin
          rp.status = bbc_pkg::ST_OVERFLOW;
        end else begin
          held_refs[pick] = held_refs[pick] + 1'b1;
        end
        rp.fill = !held_valid[pick];
        rp.hit = 1'b1;
        rp.slot = bbc_pkg::SEL_W'(pick);
        held_valid[pick] = 1'b1;
        return rp;
      end
      // Victim: unreferenced entry with the least stamp, highest index on ties.
      any_free = 0;
      oldest = bbc_pkg::TIME_MAX;
      for (int i = 0; i < bbc_pkg::ENTRIES; i++) begin
        if (held_refs[i] == '0 && held_stamp[i] <= oldest) begin
          oldest = held_stamp[i];
          pick = i;
          any_free = 1;
        end
      end
      if (!any_free) begin
        rp.slot = '0;
        rp.status = bbc_pkg::ST_NO_FREE;
        return rp;
      end
      held_dev[pick] = rq.dev;
      held_blk[pick] = rq.blk;
      held_refs[pick] = bbc_pkg::COUNT_W'(1);
      held_stamp[pick] = rq.now;
      held_valid[pick] = 1'b1;
      rp.slot = bbc_pkg::SEL_W'(pick);
      rp.fill = 1'b1;
      return rp;
    end
    if (int'(rq.idx) >= bbc_pkg::ENTRIES) begin
      return rp;
    end
    if (rq.cmd == bbc_pkg::CMD_PIN) begin
      if (held_refs[rq.idx] >= bbc_pkg::COUNT_MAX) begin
        rp.status = bbc_pkg::ST_OVERFLOW;
      end else begin
        held_refs[rq.idx] = held_refs[rq.idx] + 1'b1;
      end
      return rp;
    end
    // Release and unpin drop the count; a release that frees it stamps it.
    if (held_refs[rq.idx] == '0) begin
      rp.status = bbc_pkg::ST_UNDERFLOW;
      return rp;
    end
    held_refs[rq.idx] = held_refs[rq.idx] - 1'b1;
    if (rq.cmd == bbc_pkg::CMD_RELEASE && held_refs[rq.idx] == '0) begin
      held_stamp[rq.idx] = rq.now;
    end
    return rp;
  endfunction

  // Offers one word and returns at the edge where it is taken.
  task automatic send_word(input request_t rq);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tdata <= {{(bbc_pkg::IN_W - $bits(request_t)){1'b0}}, rq};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Sends a word, then queues what the table should answer.
  task automatic issue(input request_t rq, input bit typed, input reply_t want);
    reply_t rp;
    send_word(rq);
    rp = predict_reply(rq);
    pending_replies.push_back(typed ? want : rp);
  endtask

  task automatic wait_for_replies();
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  // Random command, biased toward hits and toward entries that hold references.
  function automatic request_t random_request(int get_pct);
    request_t rq;
    int       roll;
    int       e;
    int       live[$];
    roll = $urandom_range(99);
    rq.dev = bbc_pkg::DEV_W'($urandom);
    rq.blk = bbc_pkg::BLK_W'($urandom);
    rq.idx = bbc_pkg::SEL_W'($urandom);
    if ($urandom_range(9) == 0) begin
      rq.now = bbc_pkg::TIME_W'($urandom);
    end else begin
      tick = tick + bbc_pkg::TIME_W'($urandom_range(3));
      rq.now = tick;
    end
    if (roll < get_pct) begin
      rq.cmd = bbc_pkg::CMD_GET;
      roll = $urandom_range(99);
      if (roll < 40) begin
        e = $urandom_range(bbc_pkg::ENTRIES - 1);
        rq.dev = held_dev[e];
        rq.blk = held_blk[e];
      end else if (roll < 80) begin
        rq.dev = bbc_pkg::DEV_W'($urandom_range(3));
        rq.blk = bbc_pkg::BLK_W'($urandom_range(15));
      end
      return rq;
    end
    roll = $urandom_range(99);
    if (roll < 50) begin
      rq.cmd = bbc_pkg::CMD_RELEASE;
    end else if (roll < 75) begin
      rq.cmd = bbc_pkg::CMD_UNPIN;
    end else begin
      rq.cmd = bbc_pkg::CMD_PIN;
      return rq;
    end
    for (int i = 0; i < bbc_pkg::ENTRIES; i++) begin
      if (held_refs[i] != '0) live.push_back(i);
    end
    if (live.size() > 0 && $urandom_range(9) < 8) begin
      rq.idx = bbc_pkg::SEL_W'(live[$urandom_range(live.size() - 1)]);
    end
    return rq;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 0;
        m_axis_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each result word against the oldest expectation.
  always @(posedge clk) begin
    reply_t got;
    reply_t exp_rp;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = reply_t'(m_axis_tdata[$bits(reply_t)-1:0]);
      if (pending_replies.size() == 0) begin
        $error("result word with none expected: %h", m_axis_tdata);
        error_count++;
      end else begin
        exp_rp = pending_replies.pop_front();
        if (got.slot !== exp_rp.slot) begin
          $error("slot: expected %0d, got %0d", exp_rp.slot, got.slot);
          error_count++;
        end
        if (got.hit !== exp_rp.hit) begin
          $error("hit: expected %0d, got %0d", exp_rp.hit, got.hit);
          error_count++;
        end
        if (got.fill !== exp_rp.fill) begin
          $error("needs_fill: expected %0d, got %0d", exp_rp.fill, got.fill);
          error_count++;
        end
        if (got.status !== exp_rp.status) begin
          $error("status: expected %0d, got %0d", exp_rp.status, got.status);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither side moves a word.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    row_t     plan[$];
    request_t rq;

    for (int i = 0; i < bbc_pkg::ENTRIES; i++) begin
      held_dev[i] = '0;
      held_blk[i] = '0;
      held_valid[i] = 1'b0;
      held_refs[i] = '0;
      held_stamp[i] = '0;
    end

    // Directed commands: after reset every entry matches device 0, block 0.
    plan.push_back('{bbc_pkg::CMD_GET, 8'h00, 32'h0, 5'd0, 31'd5, 1, 0, 1,
                     '{bbc_pkg::ST_OK, 1'b1, 1'b1, 5'd0}});
    plan.push_back('{bbc_pkg::CMD_GET, 8'h00, 32'h0, 5'd0, 31'd6, 1, 0, 1,
                     '{bbc_pkg::ST_OK, 1'b0, 1'b1, 5'd0}});
    // A miss among equal stamps takes the highest free entry.
    plan.push_back('{bbc_pkg::CMD_GET, 8'hff, 32'hffffffff, 5'd0, 31'h7fffffff, 1, 0, 1,
                     '{bbc_pkg::ST_OK, 1'b1, 1'b0, 5'd31}});
    plan.push_back('{bbc_pkg::CMD_GET, 8'hff, 32'hffffffff, 5'd0, 31'd7, 1, 0, 1,
                     '{bbc_pkg::ST_OK, 1'b0, 1'b1, 5'd31}});
    // Count underflow on release and on unpin.
    plan.push_back('{bbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 5'd5, 31'd8, 1, 0, 1,
                     '{bbc_pkg::ST_UNDERFLOW, 1'b0, 1'b0, 5'd5}});
    plan.push_back('{bbc_pkg::CMD_UNPIN, 8'h00, 32'h0, 5'd6, 31'd9, 1, 0, 1,
                     '{bbc_pkg::ST_UNDERFLOW, 1'b0, 1'b0, 5'd6}});
    // Pin to saturation, then once more.
    plan.push_back('{bbc_pkg::CMD_PIN, 8'h00, 32'h0, 5'd7, 31'd10, 63, 0, 0, '0});
    plan.push_back('{bbc_pkg::CMD_PIN, 8'h00, 32'h0, 5'd7, 31'd11, 1, 0, 1,
                     '{bbc_pkg::ST_OVERFLOW, 1'b0, 1'b0, 5'd7}});
    // Hits to saturation; the saturating hit still reports the entry.
    plan.push_back('{bbc_pkg::CMD_GET, 8'h00, 32'h0, 5'd0, 31'd12, 61, 0, 0, '0});
    plan.push_back('{bbc_pkg::CMD_GET, 8'h00, 32'h0, 5'd0, 31'd13, 1, 0, 1,
                     '{bbc_pkg::ST_OVERFLOW, 1'b0, 1'b1, 5'd0}});
    plan.push_back('{bbc_pkg::CMD_UNPIN, 8'h00, 32'h0, 5'd7, 31'd14, 1, 0, 1,
                     '{bbc_pkg::ST_OK, 1'b0, 1'b0, 5'd7}});
    plan.push_back('{bbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 5'd31, 31'd100, 2, 0, 0, '0});
    // Take every free entry, then ask for one more.
    plan.push_back('{bbc_pkg::CMD_GET, 8'h01, 32'h100, 5'd0, 31'd200, 30, 1, 0, '0});
    plan.push_back('{bbc_pkg::CMD_GET, 8'ha5, 32'h5a5a5a5a, 5'd0, 31'd300, 1, 0, 1,
                     '{bbc_pkg::ST_NO_FREE, 1'b0, 1'b0, 5'd0}});
    // Freeing at the largest stamp still leaves the entry selectable.
    plan.push_back('{bbc_pkg::CMD_RELEASE, 8'hff, 32'hffffffff, 5'd31, 31'h7fffffff, 1, 0, 1,
                     '{bbc_pkg::ST_OK, 1'b0, 1'b0, 5'd31}});
    plan.push_back('{bbc_pkg::CMD_GET, 8'hff, 32'hffffffff, 5'd0, 31'd400, 1, 0, 1,
                     '{bbc_pkg::ST_OK, 1'b1, 1'b0, 5'd31}});
    plan.push_back('{bbc_pkg::CMD_RELEASE, 8'h00, 32'h0, 5'd0, 31'd500, 32, 1, 0, '0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      for (int k = 0; k < plan[r].reps; k++) begin
        rq.cmd = plan[r].cmd;
        rq.dev = plan[r].dev;
        rq.blk = plan[r].blk + (plan[r].stride ? bbc_pkg::BLK_W'(k) : '0);
        rq.idx = plan[r].idx + (plan[r].stride ? bbc_pkg::SEL_W'(k) : '0);
        rq.now = plan[r].now + bbc_pkg::TIME_W'(k);
        issue(rq, plan[r].typed, plan[r].want);
      end
    end
    tick = 31'd1000;

    // Random phases, each started from an empty pipeline.
    for (int p = 0; p < 4; p++) begin
      s_axis_tvalid <= 1'b0;
      wait_for_replies();
      send_idle_pct = SEND_PCT[p];
      recv_stall_pct = RECV_PCT[p];
      // With no idling, a long receiver hold-off backs up the input side.
      if (p == 0) stall_request = 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        issue(random_request(GET_PCT[p]), 0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    wait_for_replies();
    repeat (2 * GET_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
